// File: hdl/rpe_pkg.sv
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types, constants and elaboration-time tables for the rotary
// position embedding datapath.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int DATA_W   = 16;
  localparam int PAIR_W   = 8;
  localparam int TIME_W   = 16;
  localparam int OFF_W    = 24;
  localparam int FREQ_W   = 32;
  localparam int DIMS_W   = 9;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 9;
  localparam int POS_W    = 49;
  localparam int NUM_W    = 64;
  localparam int DEN_W    = 32;
  localparam int DIV_N    = NUM_W;
  localparam int EXP_N    = 16;
  localparam int M_W      = 33;
  localparam int ANG_W    = 62;
  localparam int CS_W     = 33;
  localparam int CORDIC_N = 16;
  localparam int Q_DEPTH  = 4;
  localparam int QA_W     = $clog2(Q_DEPTH);
  localparam int IN_W     = 112;
  localparam int OUT_W    = 56;

  localparam logic [63:0]        INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [29:0]        INV_TWO_PI_HI  = 30'h28BE60DB;
  localparam logic [31:0]        INV_TWO_PI_LO  = 32'h9391054A;
  localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
  localparam logic signed [31:0] TWO_PI_Q28     = 32'(QUARTER_PI_Q60 >>> 29);
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;

  typedef enum logic [2:0] {
    REG_ROTARY_DIMS    = 3'd0,
    REG_LOG2_BASE      = 3'd1,
    REG_POSITION_SCALE = 3'd2,
    REG_INTERLEAVED    = 3'd3,
    REG_FORWARD        = 3'd4,
    REG_CUSTOM_FREQ    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [DIMS_W-1:0] rotary_dims;
    logic [23:0]       log2_base;
    logic [23:0]       position_scale;
    logic              interleaved;
    logic              forward;
    logic              custom;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] x1;
    logic [DATA_W-1:0] x2;
    logic              pass;
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  fi;
    logic [IDX_W-1:0]  si;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    vv = v;
    for (int s = 0; s < 32; s++) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-k) in Q0.32
  function automatic logic [31:0] exp_factor(int k);
    logic [63:0] cur;
    cur = 64'd1 << 31;
    for (int i = 1; i <= EXP_N; i++) begin
      if (i <= k) cur = isqrt64(cur << 32);
    end
    return cur[31:0];
  endfunction

  // arctan(2^-i), radians Q.60
  function automatic logic signed [63:0] atan_q60(int i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int                 d;
    sum = '0;
    if (i == 0) begin
      sum = QUARTER_PI_Q60;
    end else begin
      for (int k = 0; k < 31; k++) begin
        d = 2 * k + 1;
        if (i * d < 61) begin
          term = (64'd1 << 60) >> (i * d);
          term = term / 64'(d);
          if (k[0]) sum = sum - $signed(term);
          else      sum = sum + $signed(term);
        end
      end
    end
    return sum;
  endfunction

endpackage

// File: hdl/rpe_front.sv
// ----------------------------------------------------------------------------
// rpe_front
// Input stage: unpacks a pair, classifies it against the rotary range,
// forms the position and the divider operands, and holds it for the queue.
// ----------------------------------------------------------------------------
module rpe_front (
  input  logic                        clk,
  input  logic                        rst,
  input  rpe_pkg::cfg_t               cfg,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rpe_pkg::IN_W-1:0]    s_tdata,
  input  rpe_pkg::q_stat_t            q_stat,
  output logic                        f_vld,
  output rpe_pkg::item_t              f_item
);

  localparam int X2_LO = rpe_pkg::DATA_W;
  localparam int J_LO  = X2_LO + rpe_pkg::DATA_W;
  localparam int T_LO  = J_LO + rpe_pkg::PAIR_W;
  localparam int O_LO  = T_LO + rpe_pkg::TIME_W;
  localparam int F_LO  = O_LO + rpe_pkg::OFF_W;
  localparam int TS_W  = rpe_pkg::OFF_W + 1;

  logic [rpe_pkg::DATA_W-1:0] x1, x2;
  logic [rpe_pkg::PAIR_W-1:0] j;
  logic [rpe_pkg::TIME_W-1:0] t;
  logic [rpe_pkg::OFF_W-1:0]  off;
  logic [rpe_pkg::FREQ_W-1:0] cf;
  logic [rpe_pkg::PAIR_W-1:0] half;
  logic [TS_W-1:0]            tsum;
  logic [31:0]                jl;
  rpe_pkg::item_t             item_next;
  logic                       accept;

  assign x1   = s_tdata[X2_LO-1:0];
  assign x2   = s_tdata[J_LO-1:X2_LO];
  assign j    = s_tdata[T_LO-1:J_LO];
  assign t    = s_tdata[O_LO-1:T_LO];
  assign off  = s_tdata[F_LO-1:O_LO];
  assign cf   = s_tdata[F_LO+rpe_pkg::FREQ_W-1:F_LO];
  assign half = cfg.rotary_dims[rpe_pkg::DIMS_W-1:1];
  assign tsum = TS_W'(t) + TS_W'(off);
  assign jl   = 32'(j) * 32'(cfg.log2_base);

  always_comb begin
    item_next.side.x1   = x1;
    item_next.side.x2   = x2;
    item_next.side.pass = (j >= half);
    item_next.side.pos  = rpe_pkg::POS_W'(tsum) * rpe_pkg::POS_W'(cfg.position_scale);
    if (cfg.interleaved) begin
      item_next.side.fi = {j, 1'b0};
      item_next.side.si = {j, 1'b1};
    end else begin
      item_next.side.fi = rpe_pkg::IDX_W'(j);
      item_next.side.si = rpe_pkg::IDX_W'(j) + rpe_pkg::IDX_W'(half);
    end
    if (cfg.custom) begin
      item_next.num = rpe_pkg::INV_TWO_PI_Q64;
      item_next.den = (cf == '0) ? rpe_pkg::DEN_W'(1) : cf;
    end else begin
      item_next.num = rpe_pkg::NUM_W'(jl);
      item_next.den = rpe_pkg::DEN_W'(half);
    end
  end

  assign s_tready = !f_vld || !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= 1'b1;
    end else if (!q_stat.full) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item_next;
    end
  end

endmodule

// File: hdl/rpe_queue.sv
// ----------------------------------------------------------------------------
// rpe_queue
// Short FIFO between the input stage and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rpe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rpe_pkg::item_t   push_item,
  input  logic             pop,
  output rpe_pkg::item_t   head,
  output rpe_pkg::q_stat_t stat
);

  rpe_pkg::item_t            mem [rpe_pkg::Q_DEPTH];
  logic [rpe_pkg::QA_W-1:0]  wp, rp;
  logic [rpe_pkg::QA_W:0]    cnt;
  logic                      do_push, do_pop;

  assign stat.full  = (cnt == (rpe_pkg::QA_W+1)'(rpe_pkg::Q_DEPTH));
  assign stat.empty = (cnt == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop)  rp <= rp + 1'b1;
      if (do_push && !do_pop)      cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_item;
    end
  end

endmodule

// File: hdl/rpe_divider.sv
// ----------------------------------------------------------------------------
// rpe_divider
// Pipelined restoring divider, one quotient bit per stage, shared by the
// base-power exponent and the custom-frequency reciprocal.
// ----------------------------------------------------------------------------
module rpe_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  rpe_pkg::item_t              in_item,
  output logic                        out_valid,
  output logic [rpe_pkg::NUM_W-1:0]   out_q,
  output rpe_pkg::side_t              out_side
);

  localparam int N  = rpe_pkg::DIV_N;
  localparam int DW = rpe_pkg::DEN_W;
  localparam int NW = rpe_pkg::NUM_W;

  logic              vld  [N];
  logic [DW-1:0]     rem  [N];
  logic [NW-1:0]     nq   [N];
  logic [DW-1:0]     den  [N];
  rpe_pkg::side_t    side [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic           src_vld;
    logic [DW-1:0]  src_rem;
    logic [NW-1:0]  src_nq;
    logic [DW-1:0]  src_den;
    rpe_pkg::side_t src_side;
    logic [DW:0]    trial, diff;
    logic           take;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_nq   = in_item.num;
      assign src_den  = in_item.den;
      assign src_side = in_item.side;
    end else begin : g_next
      assign src_vld  = vld[s-1];
      assign src_rem  = rem[s-1];
      assign src_nq   = nq[s-1];
      assign src_den  = den[s-1];
      assign src_side = side[s-1];
    end

    assign trial = {src_rem, src_nq[NW-1]};
    assign diff  = trial - {1'b0, src_den};
    assign take  = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        nq[s]   <= {src_nq[NW-2:0], take};
        den[s]  <= src_den;
        side[s] <= src_side;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_q     = nq[N-1];
  assign out_side  = side[N-1];

endmodule

// File: hdl/rpe_back.sv
// ----------------------------------------------------------------------------
// rpe_back
// Arithmetic back end: base power, turn phase, angle fold, CORDIC and the
// pair rotation with rounding and saturation, ending in the output register.
// ----------------------------------------------------------------------------
module rpe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  rpe_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  logic [rpe_pkg::NUM_W-1:0]   in_q,
  input  rpe_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [rpe_pkg::DATA_W-1:0]  y1,
  output logic [rpe_pkg::DATA_W-1:0]  y2,
  output logic [rpe_pkg::IDX_W-1:0]   fi,
  output logic [rpe_pkg::IDX_W-1:0]   si
);

  localparam int NW     = rpe_pkg::NUM_W;
  localparam int MW     = rpe_pkg::M_W;
  localparam int EN     = rpe_pkg::EXP_N;
  localparam int CN     = rpe_pkg::CORDIC_N;
  localparam int AW     = rpe_pkg::ANG_W;
  localparam int CW     = rpe_pkg::CS_W;
  localparam int DW     = rpe_pkg::DATA_W;
  localparam int EP_W   = MW + 32;
  localparam int HP_W   = 30 + MW;
  localparam int PROD_W = DW + CW;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - 30;
  localparam logic [MW-1:0] M_ONE = MW'(64'h1_0000_0000);
  localparam logic signed [32:0] HALF_TURN = 33'sh080000000;
  localparam logic signed [31:0] QTR_TURN  = 32'sh40000000;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'sh20000000);
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (DW - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

  function automatic logic [DW-1:0] sat(logic signed [RND_W-1:0] v);
    logic [DW-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[DW-1:0];
    else if (v < SAT_LO) r = SAT_LO[DW-1:0];
    else                 r = v[DW-1:0];
    return r;
  endfunction

  // base power 2^(-frac(e))
  logic              ex_vld  [EN];
  logic [MW-1:0]     ex_m    [EN];
  logic [NW-1:0]     ex_q    [EN];
  rpe_pkg::side_t    ex_side [EN];

  for (genvar k = 0; k < EN; k++) begin : g_exp
    localparam logic [31:0] FACTOR = rpe_pkg::exp_factor(k + 1);
    logic           src_vld;
    logic [MW-1:0]  src_m;
    logic [NW-1:0]  src_q;
    rpe_pkg::side_t src_side;
    logic [EP_W-1:0] prod;

    if (k == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_m    = M_ONE;
      assign src_q    = in_q;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = ex_vld[k-1];
      assign src_m    = ex_m[k-1];
      assign src_q    = ex_q[k-1];
      assign src_side = ex_side[k-1];
    end

    assign prod = EP_W'(src_m) * EP_W'(FACTOR);

    always_ff @(posedge clk) begin
      if (rst) begin
        ex_vld[k] <= 1'b0;
      end else if (adv) begin
        ex_vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ex_m[k]    <= src_q[EN-1-k] ? prod[EP_W-1:32] : src_m;
        ex_q[k]    <= src_q;
        ex_side[k] <= src_side;
      end
    end
  end

  // turns per position unit
  logic              w1_vld, w2_vld, w3_vld;
  logic [HP_W-1:0]   w1_hp;
  logic [EP_W-1:0]   w1_lp;
  logic [NW-1:0]     w1_q, w2_q;
  logic [NW-1:0]     w2_sum;
  logic [NW-1:0]     w3_w;
  rpe_pkg::side_t    w1_side, w2_side, w3_side;
  logic [5:0]        w_sh;
  logic              w_zero;

  assign w_sh   = 6'd16 + w2_q[21:16];
  assign w_zero = (w2_q[23:16] >= 8'd48);

  always_ff @(posedge clk) begin
    if (rst) begin
      w1_vld <= 1'b0;
      w2_vld <= 1'b0;
      w3_vld <= 1'b0;
    end else if (adv) begin
      w1_vld <= ex_vld[EN-1];
      w2_vld <= w1_vld;
      w3_vld <= w2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_hp   <= HP_W'(rpe_pkg::INV_TWO_PI_HI) * HP_W'(ex_m[EN-1]);
      w1_lp   <= EP_W'(rpe_pkg::INV_TWO_PI_LO) * EP_W'(ex_m[EN-1]);
      w1_q    <= ex_q[EN-1];
      w1_side <= ex_side[EN-1];
      w2_sum  <= NW'(w1_hp) + NW'(w1_lp[EP_W-1:32]);
      w2_q    <= w1_q;
      w2_side <= w1_side;
      if (cfg.custom)  w3_w <= w2_q;
      else if (w_zero) w3_w <= '0;
      else             w3_w <= w2_sum >> w_sh;
      w3_side <= w2_side;
    end
  end

  // phase = pos * w mod 2^64, upper word
  logic              p1_vld, p2_vld, p3_vld;
  logic [63:0]       p1_ll;
  logic [31:0]       p2_acc, p3_u;
  logic [NW-1:0]     p1_w, p2_w;
  rpe_pkg::side_t    p1_side, p2_side, p3_side;
  logic [63:0]       p2_lh, p3_hl;

  assign p2_lh = 64'(p1_side.pos[31:0]) * 64'(p1_w[63:32]);
  assign p3_hl = 64'(p2_side.pos[rpe_pkg::POS_W-1:32]) * 64'(p2_w[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= w3_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ll   <= 64'(w3_side.pos[31:0]) * 64'(w3_w[31:0]);
      p1_w    <= w3_w;
      p1_side <= w3_side;
      p2_acc  <= p1_ll[63:32] + p2_lh[31:0];
      p2_w    <= p1_w;
      p2_side <= p1_side;
      p3_u    <= p2_acc + p3_hl[31:0];
      p3_side <= p2_side;
    end
  end

  // fold to a quarter turn, then to radians
  logic                  fa_vld, z_vld;
  logic signed [31:0]    fa_a;
  logic                  fa_flip, z_flip;
  logic signed [AW-1:0]  z_z;
  rpe_pkg::side_t        fa_side, z_side;
  logic signed [31:0]    u_s;
  logic signed [32:0]    u_up, u_dn;
  logic signed [63:0]    z_prod;

  assign u_s    = $signed(p3_u);
  assign u_up   = 33'(u_s) - HALF_TURN;
  assign u_dn   = 33'(u_s) + HALF_TURN;
  assign z_prod = fa_a * rpe_pkg::TWO_PI_Q28;

  always_ff @(posedge clk) begin
    if (rst) begin
      fa_vld <= 1'b0;
      z_vld  <= 1'b0;
    end else if (adv) begin
      fa_vld <= p3_vld;
      z_vld  <= fa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (u_s > QTR_TURN) begin
        fa_a    <= u_up[31:0];
        fa_flip <= 1'b1;
      end else if (u_s < -QTR_TURN) begin
        fa_a    <= u_dn[31:0];
        fa_flip <= 1'b1;
      end else begin
        fa_a    <= u_s;
        fa_flip <= 1'b0;
      end
      fa_side <= p3_side;
      z_z     <= z_prod[AW-1:0];
      z_flip  <= fa_flip;
      z_side  <= fa_side;
    end
  end

  // CORDIC rotation mode
  logic                  c_vld  [CN];
  logic signed [CW-1:0]  c_x    [CN];
  logic signed [CW-1:0]  c_y    [CN];
  logic signed [AW-1:0]  c_z    [CN];
  logic                  c_flip [CN];
  rpe_pkg::side_t        c_side [CN];

  for (genvar i = 0; i < CN; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ATAN = AW'(rpe_pkg::atan_q60(i));
    logic                 src_vld;
    logic signed [CW-1:0] src_x, src_y;
    logic signed [AW-1:0] src_z;
    logic                 src_flip;
    rpe_pkg::side_t       src_side;
    logic signed [CW-1:0] dx, dy;

    if (i == 0) begin : g_first
      assign src_vld  = z_vld;
      assign src_x    = rpe_pkg::CORDIC_GAIN;
      assign src_y    = '0;
      assign src_z    = z_z;
      assign src_flip = z_flip;
      assign src_side = z_side;
    end else begin : g_next
      assign src_vld  = c_vld[i-1];
      assign src_x    = c_x[i-1];
      assign src_y    = c_y[i-1];
      assign src_z    = c_z[i-1];
      assign src_flip = c_flip[i-1];
      assign src_side = c_side[i-1];
    end

    assign dx = src_y >>> i;
    assign dy = src_x >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld[i] <= 1'b0;
      end else if (adv) begin
        c_vld[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!src_z[AW-1]) begin
          c_x[i] <= src_x - dx;
          c_y[i] <= src_y + dy;
          c_z[i] <= src_z - ATAN;
        end else begin
          c_x[i] <= src_x + dx;
          c_y[i] <= src_y - dy;
          c_z[i] <= src_z + ATAN;
        end
        c_flip[i] <= src_flip;
        c_side[i] <= src_side;
      end
    end
  end

  // rotate the pair
  logic                     r0_vld, r1_vld;
  logic signed [CW-1:0]     r0_cx, r0_cy;
  rpe_pkg::side_t           r0_side, r1_side;
  logic signed [PROD_W-1:0] r1_p11, r1_p22, r1_p12, r1_p21;
  logic signed [SUM_W-1:0]  v1, v2;
  logic signed [RND_W-1:0]  q1, q2;

  assign v1 = r1_p11 - r1_p22 + RND_HALF;
  assign v2 = r1_p12 + r1_p21 + RND_HALF;
  assign q1 = v1[SUM_W-1:30];
  assign q2 = v2[SUM_W-1:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_vld    <= 1'b0;
      r1_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      r0_vld    <= c_vld[CN-1];
      r1_vld    <= r0_vld;
      out_valid <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_cx   <= c_flip[CN-1] ? -c_x[CN-1] : c_x[CN-1];
      r0_cy   <= (c_flip[CN-1] ^ !cfg.forward) ? -c_y[CN-1] : c_y[CN-1];
      r0_side <= c_side[CN-1];
      r1_p11  <= $signed(r0_side.x1) * r0_cx;
      r1_p22  <= $signed(r0_side.x2) * r0_cy;
      r1_p12  <= $signed(r0_side.x1) * r0_cy;
      r1_p21  <= $signed(r0_side.x2) * r0_cx;
      r1_side <= r0_side;
      y1      <= r1_side.pass ? r1_side.x1 : sat(q1);
      y2      <= r1_side.pass ? r1_side.x2 : sat(q2);
      fi      <= r1_side.fi;
      si      <= r1_side.si;
    end
  end

endmodule

// File: hdl/rotary_position_embedding.sv
// ----------------------------------------------------------------------------
// rotary_position_embedding
// Rotary position embedding of one Q4.12 pair per transaction.
// Path from input transaction to m_tvalid includes the input stage, queue,
// 64-stage divider, 16 power stages and 16 CORDIC stages.
// Throughput: one pair per cycle; m_tready low with m_tvalid high stalls the back end.
// Reset (rst, synchronous): empties the pipeline and queue and loads register
// defaults; the block accepts a transaction in the first cycle after reset.
// ----------------------------------------------------------------------------
module rotary_position_embedding (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_wr_index,
  input  logic [rpe_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // x_first[15:0], x_second[31:16], pair_index[39:32], time_index[55:40],
  // position_offset[79:56], custom_freq[111:80]
  input  logic [rpe_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // y_first[15:0], y_second[31:16], first_index[40:32], second_index[49:41]
  output logic [rpe_pkg::OUT_W-1:0] m_tdata
);

  rpe_pkg::cfg_t                cfg;
  rpe_pkg::item_t               f_item, q_head;
  rpe_pkg::q_stat_t             q_stat;
  rpe_pkg::side_t               d_side;
  logic                         f_vld;
  logic                         adv;
  logic                         d_vld;
  logic [rpe_pkg::NUM_W-1:0]    d_q;
  logic [rpe_pkg::DATA_W-1:0]   y1, y2;
  logic [rpe_pkg::IDX_W-1:0]    fi, si;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotary_dims    <= 9'd64;
      cfg.log2_base      <= 24'd870822;
      cfg.position_scale <= 24'd65536;
      cfg.interleaved    <= 1'b0;
      cfg.forward        <= 1'b1;
      cfg.custom         <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        rpe_pkg::REG_ROTARY_DIMS:    cfg.rotary_dims    <= cfg_wr_data[rpe_pkg::DIMS_W-1:0];
        rpe_pkg::REG_LOG2_BASE:      cfg.log2_base      <= cfg_wr_data[23:0];
        rpe_pkg::REG_POSITION_SCALE: cfg.position_scale <= cfg_wr_data[23:0];
        rpe_pkg::REG_INTERLEAVED:    cfg.interleaved    <= cfg_wr_data[0];
        rpe_pkg::REG_FORWARD:        cfg.forward        <= cfg_wr_data[0];
        rpe_pkg::REG_CUSTOM_FREQ:    cfg.custom         <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign adv = !m_tvalid || m_tready;

  rpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .f_vld    (f_vld),
    .f_item   (f_item)
  );

  rpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_vld),
    .push_item (f_item),
    .pop       (adv),
    .head      (q_head),
    .stat      (q_stat)
  );

  rpe_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (!q_stat.empty),
    .in_item   (q_head),
    .out_valid (d_vld),
    .out_q     (d_q),
    .out_side  (d_side)
  );

  rpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (d_vld),
    .in_q      (d_q),
    .in_side   (d_side),
    .out_valid (m_tvalid),
    .y1        (y1),
    .y2        (y2),
    .fi        (fi),
    .si        (si)
  );

  assign m_tdata = {6'd0, si, fi, y2, y1};

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    f_vld && q_stat.full |=> f_vld && $stable(f_item))
    else $error("front item lost while queue full");

  a_front_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> f_vld)
    else $error("accepted transaction not held in front stage");

  a_queue_idle: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty && !f_vld |=> q_stat.empty)
    else $error("queue filled without a push");

endmodule

// File: test/rotary_position_embedding_tb.sv
// ----------------------------------------------------------------------------
// rotary_position_embedding_tb
// Streams rotation pairs through the RoPE block under several register
// settings and checks every output transaction, field by field, against a
// bit-exact predictor of the power/reciprocal frequency, CORDIC and rounding.
// Both stream sides idle at random, with one long stretch of full rate.
// ----------------------------------------------------------------------------
module rotary_position_embedding_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 130;

  typedef struct {
    logic signed [15:0] y1;
    logic signed [15:0] y2;
    logic [8:0]         fi;
    logic [8:0]         si;
  } rot_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [2:0]                cfg_wr_index;
  logic [rpe_pkg::CFG_W-1:0] cfg_wr_data;
  logic                      s_tvalid;
  logic                      s_tready;
  // x_first, x_second, pair_index, time_index, offset, custom_freq
  logic [rpe_pkg::IN_W-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  // y_first, y_second, first_index, second_index
  logic [rpe_pkg::OUT_W-1:0] m_tdata;

  rotary_position_embedding dut (.*);

  // register shadow
  longint unsigned dims_r, log2_base_r, scale_r, inter_r, fwd_r, custom_r;

  longint unsigned half_root[16];
  longint signed   atan_tab[16];

  logic [rpe_pkg::IN_W-1:0] pending_pairs[$];
  rot_result_t              expected_rot[$];
  int errors, checked, cycles;

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint signed clamp16(longint signed v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic rot_result_t rotate_pair(logic [rpe_pkg::IN_W-1:0] d);
    longint signed   x1, x2, cx, cy, z, a, dx, dy, v1, v2;
    longint unsigned j, t, off, cf, dims, half, pos, w, e, n, m, u;
    bit              flip;
    rot_result_t     r;
    x1 = longint'($signed(d[15:0]));
    x2 = longint'($signed(d[31:16]));
    j = 64'(d[39:32]);
    t = 64'(d[55:40]);
    off = 64'(d[79:56]);
    cf = 64'(d[111:80]);
    dims = dims_r < 512 ? dims_r : 512;
    half = dims >> 1;
    r.y1 = x1[15:0];
    r.y2 = x2[15:0];
    if (j < half) begin
      pos = (t + off) * scale_r;
      if (custom_r != 0) begin
        w = 64'h28BE60DB9391054A / (cf == 0 ? 64'd1 : cf);
      end else begin
        e = (j * log2_base_r) / half;
        n = e >> 16;
        if (n >= 48) begin
          w = 0;
        end else begin
          m = 64'd1 << 32;
          for (int b = 15; b >= 0; b--)
            if (e[b]) m = (m * half_root[b]) >> 32;
          w = ((64'h28BE60DB * m) + ((64'h9391054A * m) >> 32)) >> (16 + n);
        end
      end
      u = (pos * w) >> 32;
      a = u < (64'd1 << 31) ? longint'(u) : longint'(u) - (64'sd1 <<< 32);
      flip = 0;
      if (a > (64'sd1 <<< 30)) begin
        a = a - (64'sd1 <<< 31);
        flip = 1;
      end else if (a < -(64'sd1 <<< 30)) begin
        a = a + (64'sd1 <<< 31);
        flip = 1;
      end
      z = a * longint'(rpe_pkg::TWO_PI_Q28);
      cx = 64'sh26DD3B6A;
      cy = 0;
      for (int i = 0; i < 16; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx = cx - dx; cy = cy + dy; z = z - atan_tab[i];
        end else begin
          cx = cx + dx; cy = cy - dy; z = z + atan_tab[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      if (fwd_r != 0) begin
        v1 = x1 * cx - x2 * cy;
        v2 = x1 * cy + x2 * cx;
      end else begin
        v1 = x1 * cx + x2 * cy;
        v2 = x2 * cx - x1 * cy;
      end
      v1 = clamp16((v1 + (64'sd1 <<< 29)) >>> 30);
      v2 = clamp16((v2 + (64'sd1 <<< 29)) >>> 30);
      r.y1 = v1[15:0];
      r.y2 = v2[15:0];
    end
    if (inter_r != 0) begin
      r.fi = 9'(2 * j);
      r.si = 9'(2 * j + 1);
    end else begin
      r.fi = 9'(j);
      r.si = 9'(j + half);
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (transaction %0d)", what, got, want, checked);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic bit idle_roll();
    if (cycles > 1500 && cycles < 3500) return 0;
    return $urandom_range(99) < 9;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) expected_rot.push_back(rotate_pair(s_tdata));
      if (pending_pairs.size() > 0 && !idle_roll()) begin
        s_tdata <= pending_pairs.pop_front();
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rotary_position_embedding_tb: errors");
      $finish;
    end
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_rot.size() == 0) begin
          report("unexpected transaction", int'(m_tdata[31:0]), 0);
        end else begin
          want = expected_rot.pop_front();
          if ($signed(m_tdata[15:0]) != want.y1)
            report("y_first", int'($signed(m_tdata[15:0])), int'(want.y1));
          if ($signed(m_tdata[31:16]) != want.y2)
            report("y_second", int'($signed(m_tdata[31:16])), int'(want.y2));
          if (m_tdata[40:32] != want.fi)
            report("first_index", int'(m_tdata[40:32]), int'(want.fi));
          if (m_tdata[49:41] != want.si)
            report("second_index", int'(m_tdata[49:41]), int'(want.si));
          checked++;
        end
      end
      m_tready <= !idle_roll();
    end
  end

  task automatic write_reg(rpe_pkg::reg_index_t idx, longint unsigned v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_index <= idx;
    cfg_wr_data <= v[rpe_pkg::CFG_W-1:0];
    case (idx)
      rpe_pkg::REG_ROTARY_DIMS:    dims_r = v & 64'h1FF;
      rpe_pkg::REG_LOG2_BASE:      log2_base_r = v & 64'hFFFFFF;
      rpe_pkg::REG_POSITION_SCALE: scale_r = v & 64'hFFFFFF;
      rpe_pkg::REG_INTERLEAVED:    inter_r = v & 1;
      rpe_pkg::REG_FORWARD:        fwd_r = v & 1;
      rpe_pkg::REG_CUSTOM_FREQ:    custom_r = v & 1;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_all(longint unsigned d, longint unsigned lb, longint unsigned sc,
                         bit il, bit fw, bit cu);
    write_reg(rpe_pkg::REG_ROTARY_DIMS, d);
    write_reg(rpe_pkg::REG_LOG2_BASE, lb);
    write_reg(rpe_pkg::REG_POSITION_SCALE, sc);
    write_reg(rpe_pkg::REG_INTERLEAVED, 64'(il));
    write_reg(rpe_pkg::REG_FORWARD, 64'(fw));
    write_reg(rpe_pkg::REG_CUSTOM_FREQ, 64'(cu));
  endtask

  task automatic push_pair(logic [15:0] x1, logic [15:0] x2, logic [7:0] j, logic [15:0] t,
                           logic [23:0] off, logic [31:0] cf);
    pending_pairs.push_back({cf, off, t, j, x2, x1});
  endtask

  task automatic push_random(int count);
    logic [31:0] cf;
    logic [7:0]  j;
    logic [23:0] off;
    int          half;
    half = int'((dims_r < 512 ? dims_r : 512) >> 1);
    for (int k = 0; k < count; k++) begin
      if (half > 0 && $urandom_range(9) < 8) j = 8'($urandom_range(half > 256 ? 255 : half - 1));
      else j = 8'($urandom_range(255));
      case ($urandom_range(3))
        0: cf = $urandom_range(255) + 1;
        1: cf = $urandom_range(32'h0003_0000) + 1;
        default: cf = $urandom;
      endcase
      if (cf == 0) cf = 1;
      off = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(4095));
      push_pair(16'($urandom), 16'($urandom), j, 16'($urandom), off, cf);
    end
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || s_tvalid || expected_rot.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    longint unsigned cur;
    cur = 64'd1 << 31;
    for (int b = 15; b >= 0; b--) begin
      cur = sqrt_floor(cur << 32);
      half_root[b] = cur;
    end
    atan_tab[0] = 64'sh0C90FDAA22168C23;
    for (int i = 1; i < 16; i++) begin
      atan_tab[i] = 0;
      for (int k = 0; i * (2 * k + 1) < 61; k++) begin
        cur = ((64'd1 << 60) >> (i * (2 * k + 1))) / (2 * k + 1);
        atan_tab[i] = k[0] ? atan_tab[i] - longint'(cur) : atan_tab[i] + longint'(cur);
      end
    end
    dims_r = 64; log2_base_r = 870822; scale_r = 65536;
    inter_r = 0; fwd_r = 1; custom_r = 0;
    errors = 0; checked = 0; cycles = 0;
    rst = 1; cfg_wr_en = 0; cfg_wr_index = rpe_pkg::REG_ROTARY_DIMS; cfg_wr_data = '0;
    s_tvalid = 0; s_tdata = '0; m_tready = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // reset defaults: extremes, edge of rotary part, pass-through pairs
    push_pair(16'h7FFF, 16'h7FFF, 0, 0, 0, 1);
    push_pair(16'h8000, 16'h8000, 1, 1, 0, 1);
    push_pair(16'h7FFF, 16'h8000, 31, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
    push_pair(16'h8000, 16'h7FFF, 5, 16'hFFFF, 24'hFFFFFF, 1);
    push_pair(16'h1000, 16'h0000, 32, 100, 7, 1);
    push_pair(16'h0000, 16'hF000, 255, 3, 9, 1);
    push_pair(16'h1000, 16'h1000, 31, 1, 0, 1);
    push_pair(16'hFFFF, 16'h0001, 0, 16'hFFFF, 0, 1);
    push_pair(16'h4000, 16'hC000, 10, 777, 123456, 1);
    push_random(230);
    drain();

    set_all(256, 0, 24'hFFFFFF, 1, 0, 0);
    push_pair(16'h7FFF, 16'h8000, 127, 16'hFFFF, 24'hFFFFFF, 1);
    push_pair(16'h1000, 16'h1000, 128, 1, 1, 1);
    push_random(200);
    drain();

    set_all(511, 24'hFFFFFF, 65536, 0, 1, 0);
    push_pair(16'h7FFF, 16'h7FFF, 255, 16'hFFFF, 24'hFFFFFF, 1);
    push_random(200);
    drain();

    set_all(2, 870822, 24'h12D687, 1, 1, 1);
    push_pair(16'h7FFF, 16'h8000, 0, 16'hFFFF, 24'hFFFFFF, 1);
    push_pair(16'h8000, 16'h7FFF, 0, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
    push_pair(16'h1000, 16'h0000, 1, 5, 5, 65536);
    push_random(200);
    drain();

    set_all(0, $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF), 0, 0, 1);
    push_random(60);
    drain();

    set_all(1, $urandom_range(24'hFFFFFF), 0, 1, 1, 0);
    push_random(60);
    drain();

    set_all(64, $urandom_range(1 << 21), $urandom_range(24'hFFFFFF), 0, 0, 1);
    push_random(250);
    drain();

    set_all(128, $urandom_range(24'hFFFFFF), $urandom_range(1 << 18), 1, 0, 0);
    push_random(250);
    drain();

    $display("checked %0d output transactions over eight register settings", checked);
    $display("covered dims 0..511, both layouts, both directions, power and custom frequency");
    if (errors == 0) begin
      $display("rotary_position_embedding_tb: clean");
    end else begin
      $display("rotary_position_embedding_tb: errors");
    end
    $finish;
  end

endmodule
